@@ design/assert_macros.svh @@
// Assertion macros used by the checker file fsqm_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fsqm_pkg.sv @@
// Shared widths, request codes and side-band flags for the Q16.16 root unit.
// No dependencies; used by fsqm_root_pipe and fixed_sqrt_magnitude_unit.
`default_nettype none

package fsqm_pkg;

	localparam int OPND_W      = 32;   // Q16.16 operand
	localparam int ABS_W       = 31;   // saturated magnitude of an operand
	localparam int SQ_W        = 2 * ABS_W;
	localparam int Q_FRAC_W    = 16;
	localparam int RAD_W       = 47;   // radicand is below 2^47
	localparam int TOP_BIT_POS = 46;
	localparam int ITER        = (TOP_BIT_POS / 2) + 1;
	localparam int ROOT_W      = ITER;
	localparam int RES_W       = 31;

	localparam logic [ABS_W-1:0] HALVE_LIMIT = ABS_W'(11862016);
	localparam logic [RES_W-1:0] SAT_MAX     = {RES_W{1'b1}};

	typedef enum logic {
		REQ_SQRT = 1'b0,
		REQ_MAG  = 1'b1
	} req_t;

	typedef struct packed {
		logic halved;   // operands were halved, double the root
		logic sat;      // magnitude out of range, give SAT_MAX
	} flags_t;

endpackage

`default_nettype wire

@@ design/fixed_sqrt_magnitude_unit.sv @@
// Top level of the Q16.16 square-root / vector-magnitude unit.
// Depends on fsqm_pkg and fsqm_root_pipe.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tdata: operand_a[31:0], operand_b[63:32]; tuser: req_type
// m_*      out  tdata: root_value[30:0], bit 31 zero
//
// Pipeline registers in order: abs, halve, square, sum/saturate, 24 root stages, output.
// One item per clock while the output is not stalled; the 24 compare-subtract stages of the root set the depth.
// An item that stalls at the output freezes the whole pipeline; s_tready follows.
// arst_n clears every valid bit; no item is lost or repeated across a stall.
`default_nettype none

module fixed_sqrt_magnitude_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  wire logic [0:0]  s_tuser,   // req_type[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // root_value[30:0], zero[31]
);
	import fsqm_pkg::*;

	logic adv;

	logic [OPND_W-1:0] opnd_a;
	logic [OPND_W-1:0] opnd_b;
	logic [OPND_W-1:0] neg_a;
	logic [OPND_W-1:0] neg_b;
	logic [ABS_W-1:0]  abs_a;
	logic [ABS_W-1:0]  abs_b;

	// stage 1: saturated absolute values, square-root radicand
	logic              vld_s1;
	req_t              req_s1;
	logic [ABS_W-1:0]  abs_a_s1;
	logic [ABS_W-1:0]  abs_b_s1;
	logic [RAD_W-1:0]  rad_s1;

	// stage 2: halving
	logic              vld_s2;
	req_t              req_s2;
	logic              halved_s2;
	logic [ABS_W-1:0]  op_a_s2;
	logic [ABS_W-1:0]  op_b_s2;
	logic [RAD_W-1:0]  rad_s2;

	// stage 3: squares
	logic              vld_s3;
	req_t              req_s3;
	logic              halved_s3;
	logic [SQ_W-1:0]   sq_a_s3;
	logic [SQ_W-1:0]   sq_b_s3;
	logic [RAD_W-1:0]  rad_s3;

	// stage 4: sum, saturation, radicand select
	logic              vld_s4;
	flags_t            flg_s4;
	logic [RAD_W-1:0]  rad_s4;

	logic [SQ_W:0]     sum;
	logic [RAD_W-1:0]  scaled;
	logic              halve;

	logic              rp_valid;
	logic [ROOT_W-1:0] rp_root;
	flags_t            rp_flags;

	// stage 5: output register
	logic              vld_s5;
	logic [RES_W-1:0]  res_s5;

	assign adv      = !vld_s5 || m_tready;
	assign s_tready = adv;

	assign opnd_a = s_tdata[OPND_W-1:0];
	assign opnd_b = s_tdata[2*OPND_W-1:OPND_W];
	assign neg_a  = ~opnd_a + OPND_W'(1);
	assign neg_b  = ~opnd_b + OPND_W'(1);

	// most negative pattern negates to itself: saturate
	always_comb begin
		if (!opnd_a[OPND_W-1]) begin
			abs_a = opnd_a[ABS_W-1:0];
		end else if (neg_a[OPND_W-1]) begin
			abs_a = {ABS_W{1'b1}};
		end else begin
			abs_a = neg_a[ABS_W-1:0];
		end
		if (!opnd_b[OPND_W-1]) begin
			abs_b = opnd_b[ABS_W-1:0];
		end else if (neg_b[OPND_W-1]) begin
			abs_b = {ABS_W{1'b1}};
		end else begin
			abs_b = neg_b[ABS_W-1:0];
		end
	end

	assign halve = (req_s1 == REQ_MAG) &&
		((abs_a_s1 > HALVE_LIMIT) || (abs_b_s1 > HALVE_LIMIT));

	assign sum    = {1'b0, sq_a_s3} + {1'b0, sq_b_s3};
	assign scaled = sum[SQ_W:Q_FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= rp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1   <= req_t'(s_tuser[0]);
			abs_a_s1 <= abs_a;
			abs_b_s1 <= abs_b;
			// non-positive radicand gives a zero root
			rad_s1   <= opnd_a[OPND_W-1] ? '0 : {opnd_a[ABS_W-1:0], {Q_FRAC_W{1'b0}}};

			req_s2    <= req_s1;
			halved_s2 <= halve;
			op_a_s2   <= halve ? (abs_a_s1 >> 1) : abs_a_s1;
			op_b_s2   <= halve ? (abs_b_s1 >> 1) : abs_b_s1;
			rad_s2    <= rad_s1;

			req_s3    <= req_s2;
			halved_s3 <= halved_s2;
			sq_a_s3   <= op_a_s2 * op_a_s2;
			sq_b_s3   <= op_b_s2 * op_b_s2;
			rad_s3    <= rad_s2;

			flg_s4.halved <= halved_s3;
			flg_s4.sat    <= (req_s3 == REQ_MAG) && (scaled[RAD_W-1:ABS_W] != '0);
			rad_s4        <= (req_s3 == REQ_MAG) ?
				{scaled[ABS_W-1:0], {Q_FRAC_W{1'b0}}} : rad_s3;

			if (rp_flags.sat) begin
				res_s5 <= SAT_MAX;
			end else if (rp_flags.halved) begin
				res_s5 <= RES_W'({rp_root, 1'b0});
			end else begin
				res_s5 <= RES_W'(rp_root);
			end
		end
	end

	fsqm_root_pipe u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.in_rad    (rad_s4),
		.in_flags  (flg_s4),
		.out_valid (rp_valid),
		.out_root  (rp_root),
		.out_flags (rp_flags)
	);

	assign m_tvalid = vld_s5;
	assign m_tdata  = {1'b0, res_s5};

endmodule

`default_nettype wire

@@ design/fsqm_root_pipe.sv @@
// Pipelined bit-pair restoring square root, one result bit per stage.
// Depends on fsqm_pkg; carries flags_t side-band alongside each item.
`default_nettype none

module fsqm_root_pipe (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [fsqm_pkg::RAD_W-1:0]  in_rad,
	input  wire fsqm_pkg::flags_t            in_flags,
	output logic                             out_valid,
	output logic [fsqm_pkg::ROOT_W-1:0]      out_root,
	output fsqm_pkg::flags_t                 out_flags
);
	import fsqm_pkg::*;

	logic [RAD_W-1:0] rem_s  [ITER];
	logic [RAD_W-1:0] root_s [ITER];
	logic             vld_s  [ITER];
	flags_t           flg_s  [ITER];

	for (genvar gi = 0; gi < ITER; gi++) begin : g_iter
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (TOP_BIT_POS - 2 * gi);

		logic [RAD_W-1:0] rem_in;
		logic [RAD_W-1:0] root_in;
		logic [RAD_W-1:0] trial;
		logic             vld_in;
		flags_t           flg_in;

		if (gi == 0) begin : g_first
			assign rem_in  = in_rad;
			assign root_in = '0;
			assign vld_in  = in_valid;
			assign flg_in  = in_flags;
		end else begin : g_next
			assign rem_in  = rem_s[gi-1];
			assign root_in = root_s[gi-1];
			assign vld_in  = vld_s[gi-1];
			assign flg_in  = flg_s[gi-1];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flg_s[gi] <= flg_in;
				if (rem_in >= trial) begin
					rem_s[gi]  <= rem_in - trial;
					root_s[gi] <= (root_in >> 1) + BIT;
				end else begin
					rem_s[gi]  <= rem_in;
					root_s[gi] <= root_in >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[ITER-1];
	assign out_root  = root_s[ITER-1][ROOT_W-1:0];
	assign out_flags = flg_s[ITER-1];

endmodule

`default_nettype wire

@@ design/fsqm_checker.sv @@
// Port-level checks for fixed_sqrt_magnitude_unit, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsqm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// the first edge under reset may still see the flops uninitialised
	`ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |=> !m_tvalid, "item shown during reset")

	`ASSERT_CLK(a_stall_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled item changed")

	`ASSERT_CLK(a_stall_blocks_in, clk, arst_n, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")

	// roots stay below 2^25 unless saturated
	`ASSERT_CLK(a_root_range, clk, arst_n, m_tvalid |-> !m_tdata[31] && (m_tdata[30:25] == 6'd0 || m_tdata[30:0] == 31'h7FFFFFFF), "root out of range")

endmodule

bind fixed_sqrt_magnitude_unit fsqm_checker u_fsqm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
